@@ design/markup_tag_stripper_defines.svh @@
// Assertion macros used by the markup tag stripper checker
`ifndef MARKUP_TAG_STRIPPER_DEFINES_SVH
`define MARKUP_TAG_STRIPPER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define MTS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define MTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/mts_pkg.sv @@
// Types, constants and character codes of the markup tag stripper
`default_nettype none

package mts_pkg;

   // Queue between classifier and executor
   localparam int unsigned QUEUE_DEPTH = 4;

   // Configuration port
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] ADDR_MAX_CHARS = 2'd0;
   localparam logic [15:0] MAX_CHARS_RESET = 16'd4095;

   // Hard cap on emitted bytes per text, folded down to the counter width
   localparam int unsigned MAX_TEXT_LEN = 65535;
   localparam int unsigned CAP_FOLD = (MAX_TEXT_LEN < 65535) ? MAX_TEXT_LEN : 65535;
   localparam logic [15:0] OUT_CAP = CAP_FOLD[15:0];

   // Window geometry
   localparam int unsigned WIN_DEPTH = 8;
   localparam int unsigned VIEW_DEPTH = WIN_DEPTH + 1;
   localparam int unsigned OPEN_LEN = 7;
   localparam int unsigned CLOSE_LEN = 9;
   localparam logic [3:0] SKIP_AFTER_CLOSE = 4'd8;

   // Character codes
   localparam logic [7:0] CH_LT = 8'h3C;
   localparam logic [7:0] CH_GT = 8'h3E;
   localparam logic [7:0] CH_SP = 8'h20;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_NUL = 8'h00;

   // "<script" and "</script>"
   localparam logic [7:0] OPEN_PAT [OPEN_LEN] =
      '{8'h3C, 8'h73, 8'h63, 8'h72, 8'h69, 8'h70, 8'h74};
   localparam logic [7:0] CLOSE_PAT [CLOSE_LEN] =
      '{8'h3C, 8'h2F, 8'h73, 8'h63, 8'h72, 8'h69, 8'h70, 8'h74, 8'h3E};

   // One classified byte handed from front to back
   typedef struct packed {
      logic       term;       // end of text: emit terminator, clear state
      logic       open_hit;   // "<script" starts at this byte
      logic       close_hit;  // "</script>" starts at this byte
      logic [7:0] ch;         // the byte itself
   } job_type;

   localparam int unsigned JOB_W = $bits(job_type);

endpackage

`default_nettype wire

@@ design/mts_queue.sv @@
// Small register queue between the classifier and the executor
`default_nettype none

module mts_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  not_empty
);

   localparam int unsigned PtrW = (DEPTH < 2) ? 1 : $clog2(DEPTH);
   localparam int unsigned CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;

   assign full      = (cnt_ff == CntFull);
   assign not_empty = (cnt_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ design/mts_front.sv @@
// Front end: lookahead window, script pattern match and flush sequencing
`default_nettype none

module mts_front (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire logic [7:0]  in_char,
   input  wire logic        in_last,
   output logic             push,
   output mts_pkg::job_type push_job,
   input  wire logic        queue_full
);

   localparam int unsigned ViewN = mts_pkg::VIEW_DEPTH;

   logic [7:0] buf_ff [ViewN];
   logic [7:0] buf_in [ViewN];
   logic [7:0] view   [ViewN];
   logic [7:0] src    [ViewN];
   logic [3:0] count_ff, count_in;
   logic [3:0] src_n;
   logic       flushing_ff, flushing_in;
   logic       accept;
   logic       open_ok;
   logic       close_ok;

   assign in_ready = !flushing_ff && !queue_full;
   assign accept   = in_valid && in_ready;

   // Place the incoming byte behind the buffered ones
   always_comb begin
      for (int i = 0; i < ViewN; i++) begin
         view[i] = (count_ff == 4'(i)) ? in_char : buf_ff[i];
      end
   end

   // Match both patterns at the head of the current view
   always_comb begin
      for (int i = 0; i < ViewN; i++) begin
         src[i] = flushing_ff ? buf_ff[i] : view[i];
      end
      src_n    = flushing_ff ? count_ff : 4'(ViewN);
      open_ok  = (src_n >= 4'(mts_pkg::OPEN_LEN));
      close_ok = (src_n >= 4'(mts_pkg::CLOSE_LEN));
      for (int k = 0; k < mts_pkg::OPEN_LEN; k++) begin
         if (src[k] != mts_pkg::OPEN_PAT[k]) open_ok = 1'b0;
      end
      for (int k = 0; k < mts_pkg::CLOSE_LEN; k++) begin
         if (src[k] != mts_pkg::CLOSE_PAT[k]) close_ok = 1'b0;
      end
   end

   // Issue one classified byte, or the terminator at the end of a flush
   always_comb begin
      push_job.term      = flushing_ff && (count_ff == '0);
      push_job.open_hit  = open_ok;
      push_job.close_hit = close_ok;
      push_job.ch        = src[0];
      if (flushing_ff) begin
         push = !queue_full;
      end else begin
         push = accept && !in_last && (count_ff == 4'(mts_pkg::WIN_DEPTH));
      end
   end

   // Shift, fill or flush the window
   always_comb begin
      buf_in      = buf_ff;
      count_in    = count_ff;
      flushing_in = flushing_ff;
      if (flushing_ff) begin
         if (!queue_full) begin
            if (count_ff == '0) begin
               flushing_in = 1'b0;
            end else begin
               for (int i = 0; i < ViewN - 1; i++) begin
                  buf_in[i] = buf_ff[i+1];
               end
               count_in = count_ff - 1'b1;
            end
         end
      end else if (accept) begin
         if (in_last) begin
            buf_in      = view;
            count_in    = count_ff + 1'b1;
            flushing_in = 1'b1;
         end else if (count_ff == 4'(mts_pkg::WIN_DEPTH)) begin
            for (int i = 0; i < ViewN - 1; i++) begin
               buf_in[i] = view[i+1];
            end
         end else begin
            buf_in   = view;
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         flushing_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         flushing_ff <= flushing_in;
      end
   end

   // Hold window bytes
   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

endmodule

`default_nettype wire

@@ design/mts_back.sv @@
// Back end: tag, script, whitespace and capacity decisions, output register
`default_nettype none

module mts_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             job_valid,
   input  wire mts_pkg::job_type job,
   output logic                  pop,
   input  wire logic [15:0]      max_chars,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [7:0]            out_char,
   output logic                  out_end
);

   logic        tag_ff, tag_in;
   logic        script_ff, script_in;
   logic [3:0]  skip_ff, skip_in;
   logic [7:0]  prev_ff, prev_in;
   logic [15:0] count_ff, count_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_char_ff, out_char_in;
   logic        out_end_ff, out_end_in;
   logic [15:0] limit;
   logic        emit;
   logic [7:0]  emit_ch;

   assign limit     = (max_chars < mts_pkg::OUT_CAP) ? max_chars : mts_pkg::OUT_CAP;
   assign pop       = job_valid && (!out_valid_ff || out_ready);
   assign out_valid = out_valid_ff;
   assign out_char  = out_char_ff;
   assign out_end   = out_end_ff;

   // Decide one byte
   always_comb begin
      tag_in    = tag_ff;
      script_in = script_ff;
      skip_in   = skip_ff;
      prev_in   = prev_ff;
      count_in  = count_ff;
      emit      = 1'b0;
      emit_ch   = job.ch;
      if (pop) begin
         priority if (job.term) begin
            tag_in    = 1'b0;
            script_in = 1'b0;
            skip_in   = '0;
            prev_in   = '0;
            count_in  = '0;
         end else if (count_ff >= limit) begin
            // capacity reached: drop
         end else if (skip_ff != '0) begin
            skip_in = skip_ff - 1'b1;
         end else if (!job.open_hit && job.close_hit) begin
            script_in = 1'b0;
            skip_in   = mts_pkg::SKIP_AFTER_CLOSE;
         end else if (job.open_hit || script_ff) begin
            script_in = 1'b1;
         end else if (job.ch == mts_pkg::CH_LT) begin
            tag_in = 1'b1;
         end else if (job.ch == mts_pkg::CH_GT) begin
            tag_in = 1'b0;
         end else if (tag_ff) begin
            // inside a tag: drop
         end else if (job.ch == mts_pkg::CH_SP && count_ff != '0
                      && prev_ff == mts_pkg::CH_SP) begin
            // repeated space: drop
         end else if (job.ch == mts_pkg::CH_LF || job.ch == mts_pkg::CH_CR) begin
            if (count_ff != '0 && prev_ff != mts_pkg::CH_LF) begin
               emit    = 1'b1;
               emit_ch = mts_pkg::CH_LF;
            end
         end else begin
            emit = 1'b1;
         end
         if (emit) begin
            count_in = count_ff + 16'd1;
            prev_in  = emit_ch;
         end
      end
   end

   // Load or drain the output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_end_in   = out_end_ff;
      if (pop) begin
         out_valid_in = emit || job.term;
         out_char_in  = job.term ? mts_pkg::CH_NUL : emit_ch;
         out_end_in   = job.term;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff       <= 1'b0;
         script_ff    <= 1'b0;
         skip_ff      <= '0;
         prev_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         tag_ff       <= tag_in;
         script_ff    <= script_in;
         skip_ff      <= skip_in;
         prev_ff      <= prev_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold output payload
   always_ff @(posedge clock) begin
      out_char_ff <= out_char_in;
      out_end_ff  <= out_end_in;
   end

endmodule

`default_nettype wire

@@ design/markup_tag_stripper.sv @@
// Top level of the markup tag stripper
//
// Input stream req_*: one text byte per transaction, req_tlast on the final
// byte of a text. Output stream rsp_*: visible bytes; one terminator
// transaction (rsp_tdata zero, rsp_tlast high) closes every text.
// A CSR port holds max_chars at address 0, the cap on visible bytes per text.
//
// Throughput is one byte per cycle outside a flush while the queue has room.
// A byte is classified when the eighth byte after it arrives, since the
// script patterns span nine bytes; its result then passes through the queue
// and the output register before it appears on rsp_*. The final byte starts a
// flush that issues the remaining window bytes and the terminator, one per
// cycle while the queue has room, with req_tready low. Script matching sits in
// the front end, all per-text state sits in the back end; the QUEUE_DEPTH-entry
// queue between them lets the input keep running while rsp_tready is low until
// the queue fills, after which req_tready drops. Reset clears all control state
// and sets max_chars to 4095; the terminator clears per-text state, not max_chars.
`default_nettype none

module markup_tag_stripper #(
   parameter int unsigned QUEUE_DEPTH = mts_pkg::QUEUE_DEPTH
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // input stream
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [7:0]                     req_tdata,   // [7:0] in_char
   input  wire logic                           req_tlast,   // last_char
   // result stream
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [7:0]                          rsp_tdata,   // [7:0] out_char
   output logic                                rsp_tlast,   // is_end
   // CSR port
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [mts_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [mts_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mts_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   logic [15:0]              max_chars_ff, max_chars_in;
   logic                     csr_wr;
   logic                     push;
   mts_pkg::job_type         push_job;
   logic                     queue_full;
   logic                     pop;
   logic                     job_valid;
   logic [mts_pkg::JOB_W-1:0] pop_data;
   mts_pkg::job_type         pop_job;

   // Configuration register
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == mts_pkg::ADDR_MAX_CHARS);
   assign max_chars_in = csr_wr ? csr_pwdata[15:0] : max_chars_ff;
   assign csr_prdata = (csr_paddr == mts_pkg::ADDR_MAX_CHARS)
                       ? {{(mts_pkg::CSR_DATA_W-16){1'b0}}, max_chars_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_chars_ff <= mts_pkg::MAX_CHARS_RESET;
      end else begin
         max_chars_ff <= max_chars_in;
      end
   end

   mts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_char    (req_tdata),
      .in_last    (req_tlast),
      .push       (push),
      .push_job   (push_job),
      .queue_full (queue_full)
   );

   mts_queue #(
      .WIDTH (mts_pkg::JOB_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .not_empty (job_valid)
   );

   assign pop_job = mts_pkg::job_type'(pop_data);

   mts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (pop_job),
      .pop       (pop),
      .max_chars (max_chars_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (rsp_tdata),
      .out_end   (rsp_tlast)
   );

endmodule

`default_nettype wire

@@ design/mts_checker.sv @@
// Port-level checker for the markup tag stripper, bound to the top level
`default_nettype none
`include "markup_tag_stripper_defines.svh"

module mts_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic                           req_tlast,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [7:0]                     rsp_tdata,
   input wire logic                           rsp_tlast,
   input wire logic                           csr_pready
);

   // Stalled result holds
   `MTS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "result changed while stalled")

   // Terminator carries a zero byte
   `MTS_ASSERT_NOW(a_term_zero, rsp_tvalid && rsp_tlast, rsp_tdata == mts_pkg::CH_NUL,
      "terminator byte not zero")

   // Carriage returns never reach the output
   `MTS_ASSERT_NOW(a_no_cr, rsp_tvalid && !rsp_tlast, rsp_tdata != mts_pkg::CH_CR,
      "carriage return emitted")

   // Final byte starts a flush that blocks input
   `MTS_ASSERT_NEXT(a_flush_block, req_tvalid && req_tready && req_tlast, !req_tready,
      "input taken during flush")

   // CSR port never waits
   `MTS_ASSERT_NOW(a_pready, 1'b1, csr_pready, "csr_pready low")

endmodule

bind markup_tag_stripper mts_checker u_checker (.*);

`default_nettype wire
